@@ design/bra_pkg.sv @@
// Shared types and constants of the bitmap run allocator.
package bra_pkg;

  localparam int ROW_BITS  = 8;
  localparam int ROW_SHIFT = 3;

  localparam int OPCODE_W    = 2;
  localparam int INDEX_W     = 32;
  localparam int RUN_LEN_W   = 13;
  localparam int USED_BYTES_W = 10;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 40;

  localparam logic [OPCODE_W-1:0] OP_TEST  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_USED_BYTES = 2'd1;

  typedef struct packed {
    logic init;
    logic step;
  } scan_ctrl_t;

endpackage

@@ design/bitmap_run_allocator_unit.sv @@
// Top level of the bitmap run allocator: first-fit runs over a bit store in an 8-bit-row RAM.
// Test/write: locate, RAM read, bit op, result; out of range goes from locate to result.
// Allocate: scan R rows of 8 marks, then mark M rows, one RAM row per cycle each way;
// a full scan of the default 4096-bit store is 512 rows.
// The next input word is taken as soon as a result is handed to the output register.
// Reset (rst, synchronous) starts a pass that clears every row of the store, input stalled.
module bitmap_run_allocator_unit import bra_pkg::*; #(
  parameter int MAP_BITS = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // bit_index[31:0], write_value[32], run_length[45:33], zero fill
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  logic [OPCODE_W-1:0]    s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // bit_value[0], alloc_index[32:1], found[33], range_error[34], zero fill
  output logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ROWS = (MAP_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW   = AW + ROW_SHIFT;
  localparam int UW   = PW + 1;
  localparam int XW   = (UW > RUN_LEN_W) ? UW : RUN_LEN_W;
  localparam int SW   = ((PW > RUN_LEN_W) ? PW : RUN_LEN_W) + 1;

  typedef enum logic [9:0] {
    S_CLEAR      = 10'b0000000001,
    S_IDLE       = 10'b0000000010,
    S_LOCATE     = 10'b0000000100,
    S_BIT_RD     = 10'b0000001000,
    S_BIT_OP     = 10'b0000010000,
    S_SCAN       = 10'b0000100000,
    S_CALC       = 10'b0001000000,
    S_MARK_ISSUE = 10'b0010000000,
    S_MARK       = 10'b0100000000,
    S_DONE       = 10'b1000000000
  } state_t;

  state_t state;

  logic [INDEX_W-1:0]      index_base;
  logic [USED_BYTES_W-1:0] used_bytes;

  logic [OPCODE_W-1:0]  opcode;
  logic [INDEX_W-1:0]   bit_index;
  logic                 write_value;
  logic [RUN_LEN_W-1:0] run_length;

  logic [PW-1:0] off_pos;
  logic [AW-1:0] clr_row;
  logic [AW-1:0] data_row;
  logic          exhausted;
  logic [PW-1:0] start_pos;
  logic [AW-1:0] mark_row;

  logic                res_bit;
  logic [INDEX_W-1:0]  res_alloc;
  logic                res_found;
  logic                res_err;

  logic [XW-1:0] ub8_x;
  logic [XW-1:0] map_x;
  logic [UW-1:0] usable;
  logic [UW-1:0] usable_m1;
  logic [AW-1:0] last_row;

  logic [INDEX_W:0]    diff;
  logic                locate_ok;
  logic [SW-1:0]       start_x;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ROW_BITS-1:0] ram_rdata;

  scan_ctrl_t          scan_ctrl;
  logic                scan_hit;
  logic [PW-1:0]       end_pos;
  logic [AW-1:0]       start_row;
  logic [AW-1:0]       end_row;
  logic [ROW_BITS-1:0] mark_mask;
  logic [ROW_BITS-1:0] bit_wdata;

  logic in_fire;
  logic out_free;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ub8_x     = XW'({used_bytes, {ROW_SHIFT{1'b0}}});
  assign map_x     = XW'(MAP_BITS);
  assign usable    = UW'((ub8_x > map_x) ? map_x : ub8_x);
  assign usable_m1 = UW'(usable - 1'b1);
  assign last_row  = usable_m1[PW-1:ROW_SHIFT];

  assign diff      = {1'b0, bit_index} - {1'b0, index_base};
  assign locate_ok = !diff[INDEX_W] && (diff[INDEX_W-1:0] < INDEX_W'(usable));

  assign start_x   = SW'(end_pos) + SW'(1) - SW'(run_length);
  assign start_row = start_pos[PW-1:ROW_SHIFT];
  assign end_row   = end_pos[PW-1:ROW_SHIFT];

  always_comb begin
    logic [ROW_SHIFT-1:0] lo;
    logic [ROW_SHIFT-1:0] hi;
    lo = (mark_row == start_row) ? start_pos[ROW_SHIFT-1:0] : '0;
    hi = (mark_row == end_row) ? end_pos[ROW_SHIFT-1:0] : '1;
    for (int k = 0; k < ROW_BITS; k++) begin
      mark_mask[k] = (ROW_SHIFT'(k) >= lo) && (ROW_SHIFT'(k) <= hi);
    end
  end

  always_comb begin
    bit_wdata = ram_rdata;
    bit_wdata[off_pos[ROW_SHIFT-1:0]] = write_value;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    scan_ctrl = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row;
      end
      S_LOCATE: begin
        scan_ctrl.init = 1'b1;
      end
      S_BIT_RD: begin
        ram_raddr = off_pos[PW-1:ROW_SHIFT];
      end
      S_BIT_OP: begin
        ram_we    = (opcode == OP_WRITE);
        ram_waddr = off_pos[PW-1:ROW_SHIFT];
        ram_wdata = bit_wdata;
      end
      S_SCAN: begin
        ram_raddr      = AW'(data_row + 1'b1);
        scan_ctrl.step = !scan_hit && !exhausted;
      end
      S_MARK_ISSUE: begin
        ram_raddr = start_row;
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = mark_row;
        ram_wdata = ram_rdata | mark_mask;
        ram_raddr = AW'(mark_row + 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_base <= '0;
      used_bytes <= USED_BYTES_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INDEX_BASE: index_base <= cfg_wdata;
        REG_USED_BYTES: used_bytes <= cfg_wdata[USED_BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      m_tvalid  <= 1'b0;
      res_found <= 1'b0;
      res_err   <= 1'b0;
      exhausted <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= AW'(clr_row + 1'b1);
          if (clr_row == AW'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            opcode      <= s_tuser;
            bit_index   <= s_tdata[31:0];
            write_value <= s_tdata[32];
            run_length  <= s_tdata[45:33];
            res_bit     <= 1'b0;
            res_alloc   <= '0;
            res_found   <= 1'b0;
            res_err     <= 1'b0;
            state       <= S_LOCATE;
          end
        end
        S_LOCATE: begin
          off_pos   <= diff[PW-1:0];
          data_row  <= '0;
          exhausted <= 1'b0;
          case (opcode)
            OP_TEST, OP_WRITE: begin
              if (locate_ok) begin
                state <= S_BIT_RD;
              end else begin
                res_err <= 1'b1;
                state   <= S_DONE;
              end
            end
            OP_ALLOC: begin
              if (usable == '0) begin
                state <= S_DONE;
              end else if (run_length == '0) begin
                res_found <= 1'b1;
                res_alloc <= index_base;
                state     <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_BIT_RD: begin
          state <= S_BIT_OP;
        end
        S_BIT_OP: begin
          if (opcode == OP_TEST) begin
            res_bit <= ram_rdata[off_pos[ROW_SHIFT-1:0]];
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (scan_hit) begin
            state <= S_CALC;
          end else if (exhausted) begin
            state <= S_DONE;
          end else if (data_row == last_row) begin
            exhausted <= 1'b1;
          end else begin
            data_row <= AW'(data_row + 1'b1);
          end
        end
        S_CALC: begin
          start_pos <= start_x[PW-1:0];
          state     <= S_MARK_ISSUE;
        end
        S_MARK_ISSUE: begin
          mark_row <= start_row;
          state    <= S_MARK;
        end
        S_MARK: begin
          if (mark_row == end_row) begin
            res_found <= 1'b1;
            res_alloc <= index_base + INDEX_W'(start_pos);
            state     <= S_DONE;
          end else begin
            mark_row <= AW'(mark_row + 1'b1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, res_err, res_found, res_alloc, res_bit};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bra_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROWS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bra_run_scan #(
    .AW(AW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .run_length(run_length),
    .row       (data_row),
    .row_data  (ram_rdata),
    .usable    (usable),
    .hit       (scan_hit),
    .end_pos   (end_pos)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_found |-> !res_err)
    else $error("found and range error both set");

  a_accept_to_locate: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_LOCATE))
    else $error("accepted word did not start a lookup");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result word raised outside the done state");

  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> ((mark_row >= start_row) && (mark_row <= end_row)))
    else $error("mark row outside the allocated run");

endmodule

@@ design/bra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bra_run_scan.sv @@
// Free-run counter that walks the store one 8-bit row per step.
module bra_run_scan import bra_pkg::*; #(
  parameter int AW = 9,
  localparam int PW = AW + ROW_SHIFT,
  localparam int UW = PW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_ctrl_t           ctrl,
  input  logic [RUN_LEN_W-1:0] run_length,
  input  logic [AW-1:0]        row,
  input  logic [ROW_BITS-1:0]  row_data,
  input  logic [UW-1:0]        usable,
  output logic                 hit,
  output logic [PW-1:0]        end_pos
);

  logic [RUN_LEN_W-1:0] cnt;
  logic [RUN_LEN_W-1:0] cnt_next;
  logic                 hit_next;
  logic [PW-1:0]        end_pos_next;

  always_comb begin
    logic [PW-1:0] pos;
    cnt_next     = cnt;
    hit_next     = hit;
    end_pos_next = end_pos;
    for (int k = 0; k < ROW_BITS; k++) begin
      pos = {row, ROW_SHIFT'(k)};
      if (!hit_next && ({1'b0, pos} < usable)) begin
        if (row_data[k]) begin
          cnt_next = '0;
        end else begin
          cnt_next = RUN_LEN_W'(cnt_next + 1'b1);
        end
        if (cnt_next == run_length) begin
          hit_next     = 1'b1;
          end_pos_next = pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      hit <= 1'b0;
    end else if (ctrl.init) begin
      cnt <= '0;
      hit <= 1'b0;
    end else if (ctrl.step) begin
      cnt     <= cnt_next;
      hit     <= hit_next;
      end_pos <= end_pos_next;
    end
  end

endmodule
